>>> hdl/pel_pkg.sv
package pel_pkg;

    localparam int MODE_W = 3;
    localparam int POS_W = 5;
    localparam int VALUE_W = 32;
    localparam int LEN_W = 5;

    localparam logic [MODE_W-1:0] MODE_READ_AT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT_AT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE_AT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DROP_LAST = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_LAST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_POP_FIRST = 3'd6;

    typedef struct packed {
        logic capture;
        logic execute;
    } pel_cmd_t;

endpackage

>>> hdl/pel_datapath.sv
module pel_datapath
    import pel_pkg::*;
#(
    parameter int MAX_LEN = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pel_cmd_t                  cmd,
    input  logic [MODE_W-1:0]         mode,
    input  logic [POS_W-1:0]          position,
    input  logic signed [VALUE_W-1:0] item_value,
    output logic                      ok,
    output logic signed [VALUE_W-1:0] read_value,
    output logic [LEN_W-1:0]          length
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [MODE_W-1:0]         mode_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic signed [VALUE_W-1:0] entries_reg [MAX_LEN];
    logic signed [VALUE_W-1:0] entries_next [MAX_LEN];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      ok_reg;
    logic                      ok_next;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic signed [VALUE_W-1:0] read_value_next;

    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] target;
    logic             do_insert;
    logic             do_delete;
    logic             do_read;
    logic             not_full;
    logic             not_empty;

    assign pos_ext   = EXT_W'(pos_reg);
    assign cnt_ext   = EXT_W'(count_reg);
    assign not_full  = cnt_ext < EXT_W'(MAX_LEN);
    assign not_empty = count_reg != '0;

    always_comb begin
        do_insert = 1'b0;
        do_delete = 1'b0;
        do_read   = 1'b0;
        target    = pos_ext;
        unique case (mode_reg)
            MODE_READ_AT: begin
                do_read = pos_ext < cnt_ext;
            end
            MODE_INSERT_AT: begin
                do_insert = not_full && (pos_ext <= cnt_ext);
            end
            MODE_DELETE_AT: begin
                do_delete = pos_ext < cnt_ext;
            end
            MODE_APPEND: begin
                target    = cnt_ext;
                do_insert = not_full;
            end
            MODE_DROP_LAST: begin
                target    = cnt_ext - EXT_W'(1);
                do_delete = not_empty;
            end
            MODE_READ_LAST: begin
                target  = cnt_ext - EXT_W'(1);
                do_read = not_empty;
            end
            MODE_POP_FIRST: begin
                target    = '0;
                do_read   = not_empty;
                do_delete = not_empty;
            end
            default: begin
                target = pos_ext;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_LEN; i++) begin
            entries_next[i] = entries_reg[i];
            if (do_insert) begin
                if (EXT_W'(i) == target) begin
                    entries_next[i] = value_reg;
                end else if (i > 0 && EXT_W'(i) > target) begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (do_delete) begin
                if (i < MAX_LEN - 1 && EXT_W'(i) >= target) begin
                    entries_next[i] = entries_reg[(i < MAX_LEN - 1) ? i + 1 : i];
                end
            end
        end
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_delete) begin
            count_next = count_reg - CNT_W'(1);
        end
        ok_next         = do_insert || do_delete || do_read;
        read_value_next = do_read ? entries_reg[target[IDX_W-1:0]] : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= mode;
            pos_reg   <= position;
            value_reg <= item_value;
        end
        if (cmd.execute) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                entries_reg[i] <= entries_next[i];
            end
            ok_reg         <= ok_next;
            read_value_reg <= read_value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    logic [EXT_W-1:0] len_ext;
    assign len_ext = EXT_W'(count_reg);

    assign ok         = ok_reg;
    assign read_value = read_value_reg;
    assign length     = len_ext[LEN_W-1:0];

endmodule

>>> hdl/pel_controller.sv
module pel_controller
    import pel_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output pel_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= ST_EXEC;
                        s_tready_reg <= 1'b0;
                    end else begin
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_EXEC: begin
                    state_reg    <= ST_RESP;
                    m_tvalid_reg <= 1'b1;
                end
                ST_RESP: begin
                    if (m_tready) begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready    = s_tready_reg;
    assign m_tvalid    = m_tvalid_reg;
    assign cmd.capture = s_tvalid && s_tready_reg;
    assign cmd.execute = state_reg == ST_EXEC;

endmodule

>>> hdl/positional_list_engine_top.sv
// Ordered list of up to MAX_LEN signed 32-bit entries addressed by position.
// The slave channel carries one request word: an operation code, a position
// and a value. The master channel returns one response word per request:
// a success flag, the value read and the list length after the request.
// A request is captured on acceptance, carried out in the next cycle, and
// its response is valid from the cycle after that. One request is in
// flight at a time; a new request is accepted only after the response has
// been taken, following the capture, execute and response steps of the
// controller. Inserts and deletes move every entry behind the position
// together through a shift array of registers.
// Reset clears the list to empty and drops any pending response; s_tready
// rises after reset is released. When the receiver stalls, the response
// word holds and no new request is accepted until it is taken.
module positional_list_engine_top
    import pel_pkg::*;
#(
    parameter int MAX_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode [2:0], position [7:3], item_value [39:8]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok [0], read_value [32:1], length [37:33], zero [39:38]
    output logic [39:0] m_tdata
);

    pel_cmd_t                  cmd;
    logic                      ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          length;

    pel_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pel_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .mode       (s_tdata[2:0]),
        .position   (s_tdata[7:3]),
        .item_value (s_tdata[39:8]),
        .ok         (ok),
        .read_value (read_value),
        .length     (length)
    );

    assign m_tdata = {2'b00, length, read_value, ok};

endmodule
